/* rtl/core/hdmc_pkg.sv */
// Shared types, codes and constants of the hashed direct-mapped lookup cache.
package hdmc_pkg;

  localparam int unsigned SLOTS_DEF = 4096;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned FTYPE_W = 4;
  localparam int unsigned TYPE_W  = 3;
  localparam int unsigned TAG_W   = 2 * ADDR_W;
  localparam int unsigned ENTRY_W = TAG_W + VAL_W + TYPE_W;
  localparam int unsigned CNT_W   = 32;

  // Hash fold shifts and the largest type that is kept in the store.
  localparam int unsigned TBL_SHIFT = 16;
  localparam int unsigned KEY_SHIFT = 14;
  localparam logic [FTYPE_W-1:0] TYPE_MAX = 4'd4;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    OUT_BYPASS  = 3'd0,
    OUT_HIT     = 3'd1,
    OUT_MISS    = 3'd2,
    OUT_FILLED  = 3'd3,
    OUT_SKIPPED = 3'd4,
    OUT_CLEARED = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_LOOK,
    ST_SWEEP,
    ST_CLR_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [ADDR_W-1:0]  table_address;
    logic [ADDR_W-1:0]  key_address;
    logic               bypass;
    logic [VAL_W-1:0]   fill_value;
    logic [FTYPE_W-1:0] fill_type;
  } req_t;

  typedef struct packed {
    logic [2:0]        outcome;
    logic [VAL_W-1:0]  cached_value;
    logic [TYPE_W-1:0] cached_type;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic mem_rd;
    logic mem_wr;
    logic sweep;
    logic res_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic idx_ready;
    logic is_clear;
    logic is_lookup;
    logic is_fill;
    logic fill_ok;
    logic sweep_last;
    logic out_free;
  } ctl_sts_t;

endpackage

/* rtl/core/hdmc_req_if.sv */
// Request channel: valid/ready handshake with the lookup request payload.
interface hdmc_req_if;
  logic          valid;
  logic          ready;
  hdmc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/hdmc_rsp_if.sv */
// Response channel: valid/ready handshake with the lookup result payload.
interface hdmc_rsp_if;
  logic          valid;
  logic          ready;
  hdmc_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/hdmc_ram.sv */
// Generic single-port RAM with registered read data.
module hdmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/hdmc_ctrl.sv */
// Control state machine: request intake, store sweep, lookup and result sequencing.
module hdmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hdmc_pkg::ctl_sts_t  sts_i,
  output hdmc_pkg::ctl_cmd_t  cmd_o
);
  import hdmc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.idx_ready) begin
          if (sts_i.is_clear) begin
            state_d = ST_SWEEP;
          end else if (sts_i.is_lookup) begin
            cmd_o.mem_rd = 1'b1;
            state_d      = ST_LOOK;
          end else if (sts_i.out_free) begin
            // write the slot in the same cycle the result is committed
            cmd_o.res_load = 1'b1;
            cmd_o.mem_wr   = sts_i.is_fill & sts_i.fill_ok;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_LOOK: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_CLR_DONE;
        end
      end
      ST_CLR_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

/* rtl/core/hdmc_datapath.sv */
// Datapath: request register, slot hash, slot store, counters and result register.
module hdmc_datapath #(
  parameter int unsigned SLOTS = hdmc_pkg::SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hdmc_pkg::req_t      req_data_i,
  input  hdmc_pkg::ctl_cmd_t  cmd_i,
  output hdmc_pkg::ctl_sts_t  sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output hdmc_pkg::rsp_t      rsp_data_o
);
  import hdmc_pkg::*;

  localparam int unsigned IdxW   = $clog2(SLOTS);
  localparam bit          IsPow2 = (SLOTS & (SLOTS - 1)) == 0;

  req_t req_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_data_i;
    end
  end

  logic [ADDR_W-1:0] hash;
  logic [IdxW-1:0]   idx;
  logic              idx_ready;

  assign hash = req_q.table_address ^ (req_q.table_address >> TBL_SHIFT)
              ^ req_q.key_address ^ (req_q.key_address >> KEY_SHIFT);

  if (IsPow2) begin : g_pow2
    assign idx       = hash[IdxW-1:0];
    assign idx_ready = 1'b1;
  end else begin : g_mod
    // Remainder by reciprocal multiplication in registered steps: quotient
    // estimate, its product with the slot count, then subtract and correct.
    localparam logic [ADDR_W-1:0] Recip = ADDR_W'((64'd1 << ADDR_W) / 64'(SLOTS));

    logic [1:0]          stage_q;
    logic [2*ADDR_W-1:0] prod_wide;
    logic [ADDR_W-1:0]   quot_q, back_q, diff, rem_full;
    logic [IdxW-1:0]     rem_q;

    assign prod_wide = {{ADDR_W{1'b0}}, hash} * {{ADDR_W{1'b0}}, Recip};
    assign diff      = hash - back_q;
    // the estimate is low by at most one, so one subtract suffices
    assign rem_full  = (diff >= ADDR_W'(SLOTS)) ? diff - ADDR_W'(SLOTS) : diff;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q <= 2'd3;
        quot_q  <= '0;
        back_q  <= '0;
        rem_q   <= '0;
      end else if (cmd_i.load_req) begin
        stage_q <= 2'd0;
      end else if (stage_q != 2'd3) begin
        stage_q <= stage_q + 2'd1;
        quot_q  <= prod_wide[2*ADDR_W-1:ADDR_W];
        back_q  <= quot_q * ADDR_W'(SLOTS);
        rem_q   <= rem_full[IdxW-1:0];
      end
    end

    assign idx       = rem_q;
    assign idx_ready = stage_q == 2'd3;
  end

  // Sweep counter wraps to zero after the last slot, ready for the next pass.
  logic [IdxW-1:0] sweep_q;
  logic            sweep_last;

  assign sweep_last = sweep_q == IdxW'(SLOTS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_last ? '0 : sweep_q + IdxW'(1);
    end
  end

  logic [ENTRY_W-1:0] wdata, rdata;
  logic [IdxW-1:0]    addr;
  logic [TAG_W-1:0]   req_tag, rd_tag;
  logic [VAL_W-1:0]   rd_value;
  logic [TYPE_W-1:0]  rd_type;

  assign req_tag = {req_q.table_address, req_q.key_address};
  assign addr    = cmd_i.sweep ? sweep_q : idx;
  assign wdata   = cmd_i.sweep ? '0
                 : {req_tag, req_q.fill_value, req_q.fill_type[TYPE_W-1:0]};
  assign {rd_tag, rd_value, rd_type} = rdata;

  hdmc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sweep | cmd_i.mem_wr),
    .re_i    (cmd_i.mem_rd),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  logic active, is_clear, is_lookup, is_fill, fill_ok, hit;

  assign active    = (req_q.key_address != '0) && !req_q.bypass;
  assign is_clear  = req_q.command == CMD_CLEAR;
  assign is_lookup = (req_q.command == CMD_LOOKUP) && active;
  assign is_fill   = (req_q.command == CMD_FILL) && active;
  assign fill_ok   = req_q.fill_type <= TYPE_MAX;
  assign hit       = (rd_tag == req_tag) && (rd_type <= TYPE_MAX[TYPE_W-1:0]);

  logic [2:0] outcome;

  always_comb begin
    outcome = OUT_BYPASS;
    if (is_clear) begin
      outcome = OUT_CLEARED;
    end else if (is_lookup) begin
      outcome = hit ? OUT_HIT : OUT_MISS;
    end else if (is_fill) begin
      outcome = fill_ok ? OUT_FILLED : OUT_SKIPPED;
    end
  end

  logic [CNT_W-1:0] hit_q, hit_d, miss_q, miss_d;
  logic             hit_evt, miss_evt;

  assign hit_evt  = cmd_i.res_load && is_lookup && hit;
  assign miss_evt = cmd_i.res_load && is_lookup && !hit;
  assign hit_d    = (hit_evt && hit_q != '1) ? hit_q + CNT_W'(1) : hit_q;
  assign miss_d   = (miss_evt && miss_q != '1) ? miss_q + CNT_W'(1) : miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= '0;
      miss_q <= '0;
    end else begin
      hit_q  <= hit_d;
      miss_q <= miss_d;
    end
  end

  // Result register: holds until the downstream side takes the transfer.
  logic out_valid_q;
  rsp_t rsp_q;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      rsp_q.outcome      <= outcome;
      rsp_q.cached_value <= (is_lookup && hit) ? rd_value : '0;
      rsp_q.cached_type  <= (is_lookup && hit) ? rd_type : '0;
      rsp_q.hit_total    <= hit_d;
      rsp_q.miss_total   <= miss_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_data_o  = rsp_q;

  assign sts_o.idx_ready  = idx_ready;
  assign sts_o.is_clear   = is_clear;
  assign sts_o.is_lookup  = is_lookup;
  assign sts_o.is_fill    = is_fill;
  assign sts_o.fill_ok    = fill_ok;
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = out_free;

endmodule

/* rtl/core/hashed_direct_mapped_lookup_cache_top.sv */
// Hashed direct-mapped lookup cache: one request in, one result out per request.
// Lookup: accept to result through the request register, RAM read and result register.
// Fill, bypass and unused command: request register, then result register; one request in flight at a time.
// Non-power-of-two SLOTS adds the index remainder steps to every request.
// Clear: a store sweep, one slot per cycle, then the result.
// Reset: counters zero; a sweep of every slot zeroes the store before the first request.
module hashed_direct_mapped_lookup_cache_top #(
  parameter int unsigned SLOTS = hdmc_pkg::SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hdmc_req_if.sink          req_i,
  hdmc_rsp_if.source        rsp_o
);
  import hdmc_pkg::*;

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;
  logic     in_ready;
  logic     out_valid;
  rsp_t     rsp_data;

  hdmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd)
  );

  hdmc_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.data),
    .cmd_i       (ctl_cmd),
    .sts_o       (ctl_sts),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (out_valid),
    .rsp_data_o  (rsp_data)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;
  assign rsp_o.data  = rsp_data;

endmodule

/* verif/hashed_direct_mapped_lookup_cache_top_tb.sv */
// Self-checking testbench of the hashed direct-mapped lookup cache: directed and random traffic.
module hashed_direct_mapped_lookup_cache_top_tb;
  import hdmc_pkg::*;

  localparam int unsigned SLOTS      = SLOTS_DEF;
  localparam int unsigned POOL_N     = 16;
  localparam int unsigned MAX_CLEARS = 12;
  localparam int unsigned PRINT_CAP  = 40;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic idling_on = 1'b1;

  hdmc_req_if req_if ();
  hdmc_rsp_if rsp_if ();

  hashed_direct_mapped_lookup_cache_top #(
    .SLOTS (SLOTS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the store and counters
  logic [TAG_W-1:0]  shadow_tag   [SLOTS];
  logic [VAL_W-1:0]  shadow_value [SLOTS];
  logic [TYPE_W-1:0] shadow_type  [SLOTS];
  logic [CNT_W-1:0]  shadow_hits;
  logic [CNT_W-1:0]  shadow_misses;

  rsp_t        pending_results [$];
  rsp_t        oldest_result;
  int unsigned err_count   = 0;
  int unsigned items_sent  = 0;
  int unsigned clears_sent = 0;

  // Address pairs; entry i and i+POOL_N/2 share a slot but differ in tag
  logic [ADDR_W-1:0] pool_t [POOL_N];
  logic [ADDR_W-1:0] pool_k [POOL_N];

  function automatic void clear_shadow();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_tag[i]   = '0;
      shadow_value[i] = '0;
      shadow_type[i]  = '0;
    end
  endfunction

  function automatic rsp_t predict_lookup(input req_t r);
    rsp_t              res;
    logic [ADDR_W-1:0] fold;
    int unsigned       idx;
    logic [TAG_W-1:0]  tag;
    res = '0;
    res.outcome = OUT_BYPASS;
    if (r.command == CMD_CLEAR) begin
      clear_shadow();
      res.outcome = OUT_CLEARED;
    end else if ((r.command == CMD_LOOKUP || r.command == CMD_FILL) && !r.bypass &&
                 r.key_address != '0) begin
      fold = r.table_address ^ (r.table_address >> TBL_SHIFT) ^
             r.key_address ^ (r.key_address >> KEY_SHIFT);
      idx  = fold % SLOTS;
      tag  = {r.table_address, r.key_address};
      if (r.command == CMD_LOOKUP) begin
        if (shadow_tag[idx] == tag && {1'b0, shadow_type[idx]} <= TYPE_MAX) begin
          res.outcome      = OUT_HIT;
          res.cached_value = shadow_value[idx];
          res.cached_type  = shadow_type[idx];
          if (shadow_hits != '1) shadow_hits++;
        end else begin
          res.outcome = OUT_MISS;
          if (shadow_misses != '1) shadow_misses++;
        end
      end else if (r.fill_type <= TYPE_MAX) begin
        shadow_tag[idx]   = tag;
        shadow_value[idx] = r.fill_value;
        shadow_type[idx]  = r.fill_type[TYPE_W-1:0];
        res.outcome       = OUT_FILLED;
      end else begin
        res.outcome = OUT_SKIPPED;
      end
    end
    res.hit_total  = shadow_hits;
    res.miss_total = shadow_misses;
    return res;
  endfunction

  function automatic req_t make_req(input logic [1:0] cmd, input logic [ADDR_W-1:0] t,
                                    input logic [ADDR_W-1:0] k, input logic byp,
                                    input logic [VAL_W-1:0] val,
                                    input logic [FTYPE_W-1:0] typ);
    req_t r;
    r.command       = cmd;
    r.table_address = t;
    r.key_address   = k;
    r.bypass        = byp;
    r.fill_value    = val;
    r.fill_type     = typ;
    return r;
  endfunction

  // Noise: any field value, but never a clear (those are rationed)
  function automatic req_t random_request();
    logic [1:0] cmd;
    cmd = 2'($urandom_range(0, 2));
    if (cmd == CMD_CLEAR) cmd = CMD_UNUSED;
    return make_req(cmd, $urandom(), ($urandom_range(0, 7) == 0) ? '0 : $urandom(),
                    1'($urandom_range(0, 1)), {$urandom(), $urandom()},
                    4'($urandom_range(0, 15)));
  endfunction

  function automatic req_t pool_request(input int unsigned slot, input logic [1:0] cmd);
    logic [FTYPE_W-1:0] typ;
    typ = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(5, 15)) : 4'($urandom_range(0, 4));
    return make_req(cmd, pool_t[slot], pool_k[slot], ($urandom_range(0, 19) == 0),
                    {$urandom(), $urandom()}, typ);
  endfunction

  function automatic void refresh_pool_pair(input int unsigned i);
    pool_t[i] = $urandom();
    pool_k[i] = $urandom() | 32'h2;
    // flipping bit 0 of both addresses leaves the fold unchanged
    pool_t[i + POOL_N / 2] = pool_t[i] ^ 32'h1;
    pool_k[i + POOL_N / 2] = pool_k[i] ^ 32'h1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < PRINT_CAP)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  // Hold valid high until the transfer; the next call either reloads or drops it
  task automatic send_request(input req_t r);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_lookup(r));
    items_sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_mix(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned slot;
    req_t        r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 2 && clears_sent < MAX_CLEARS) begin
        r = random_request();
        r.command = CMD_CLEAR;
        send_request(r);
        clears_sent++;
      end else if (pick < 14) begin
        send_request(random_request());
      end else begin
        slot = $urandom_range(0, POOL_N - 1);
        if ($urandom_range(0, 19) == 0) refresh_pool_pair(slot % (POOL_N / 2));
        send_request(pool_request(slot, CMD_LOOKUP));
        if ($urandom_range(0, 9) < 6) begin
          send_request(pool_request(slot, CMD_FILL));
          send_request(pool_request(slot, CMD_LOOKUP));
        end
      end
    end
  endtask

  task automatic test_directed_cases();
    logic [ADDR_W-1:0] ta;
    logic [ADDR_W-1:0] ka;
    ta = '1;
    ka = '1;
    send_request(make_req(CMD_LOOKUP, '0, '0, 1'b0, '0, '0));       // zero key
    send_request(make_req(CMD_LOOKUP, ta, ka, 1'b0, '0, '0));       // miss
    send_request(make_req(CMD_FILL, ta, ka, 1'b0, '1, 4'd4));
    send_request(make_req(CMD_LOOKUP, ta, ka, 1'b0, '0, '0));       // hit, all ones
    send_request(make_req(CMD_LOOKUP, ta, ka, 1'b1, '0, '0));       // bypass flag
    send_request(make_req(CMD_FILL, ta, ka, 1'b1, '0, 4'd0));       // bypassed fill
    send_request(make_req(CMD_FILL, ta, '0, 1'b0, '0, 4'd0));       // zero-key fill
    send_request(make_req(CMD_LOOKUP, ta, ka, 1'b0, '0, '0));
    send_request(make_req(CMD_FILL, ta, ka, 1'b0, 64'h0123_4567_89AB_CDEF, 4'd0));
    send_request(make_req(CMD_LOOKUP, ta, ka, 1'b0, '0, '0));       // hit with type zero
    send_request(make_req(CMD_FILL, ta, ka, 1'b0, '0, 4'd5));       // type too large
    send_request(make_req(CMD_FILL, ta, ka, 1'b0, '0, 4'd15));
    send_request(make_req(CMD_LOOKUP, ta, ka, 1'b0, '0, '0));
    // same slot, different tag: evict and re-miss
    send_request(make_req(CMD_LOOKUP, ta ^ 32'h1, ka ^ 32'h1, 1'b0, '0, '0));
    send_request(make_req(CMD_FILL, ta ^ 32'h1, ka ^ 32'h1, 1'b0, 64'h8000_0000_0000_0001,
                          4'd2));
    send_request(make_req(CMD_LOOKUP, ta, ka, 1'b0, '0, '0));
    send_request(make_req(CMD_LOOKUP, ta ^ 32'h1, ka ^ 32'h1, 1'b0, '0, '0));
    send_request(make_req(CMD_UNUSED, ta, ka, 1'b0, '1, 4'd1));
    send_request(make_req(CMD_FILL, '0, 32'h1, 1'b0, 64'h5555_AAAA_5555_AAAA, 4'd1));
    send_request(make_req(CMD_LOOKUP, '0, 32'h1, 1'b0, '0, '0));
    send_request(make_req(CMD_CLEAR, ta, '0, 1'b1, '1, 4'd15));     // clear ignores bypass
    send_request(make_req(CMD_LOOKUP, '0, 32'h1, 1'b0, '0, '0));
    send_request(make_req(CMD_LOOKUP, ta ^ 32'h1, ka ^ 32'h1, 1'b0, '0, '0));
    send_request(make_req(CMD_LOOKUP, '0, 32'h8000_0000, 1'b0, '0, '0));  // cleared slot
    drain();
  endtask

  task automatic test_random_traffic();
    random_mix(930);
    drain();
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    random_mix(100);
    drain();
  endtask

  // Result side: stall in random bursts while idling_on is set
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, outcome", 64'(rsp_if.data.outcome), '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_if.data.outcome !== oldest_result.outcome)
          report_mismatch("outcome", 64'(rsp_if.data.outcome), 64'(oldest_result.outcome));
        if (rsp_if.data.cached_value !== oldest_result.cached_value)
          report_mismatch("cached_value", rsp_if.data.cached_value,
                          oldest_result.cached_value);
        if (rsp_if.data.cached_type !== oldest_result.cached_type)
          report_mismatch("cached_type", 64'(rsp_if.data.cached_type),
                          64'(oldest_result.cached_type));
        if (rsp_if.data.hit_total !== oldest_result.hit_total)
          report_mismatch("hit_total", 64'(rsp_if.data.hit_total),
                          64'(oldest_result.hit_total));
        if (rsp_if.data.miss_total !== oldest_result.miss_total)
          report_mismatch("miss_total", 64'(rsp_if.data.miss_total),
                          64'(oldest_result.miss_total));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    clear_shadow();
    shadow_hits   = '0;
    shadow_misses = '0;
    for (int i = 0; i < POOL_N / 2; i++) refresh_pool_pair(i);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_traffic();
    test_back_to_back();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/hdmc_pkg.sv
rtl/core/hdmc_req_if.sv
rtl/core/hdmc_rsp_if.sv
rtl/core/hdmc_ram.sv
rtl/core/hdmc_ctrl.sv
rtl/core/hdmc_datapath.sv
rtl/core/hashed_direct_mapped_lookup_cache_top.sv
verif/hashed_direct_mapped_lookup_cache_top_tb.sv
